@@ rtl/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg: shared definitions for the bitmap block allocator
// Field widths of the request and result ports, and the command codes.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  // Field widths
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned START_W = 10;
  localparam int unsigned CNT_W   = 11;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_RESERVE = 2'd3
  } cmd_e;

endpackage : bba_pkg

`default_nettype wire

@@ rtl/bba_ram.sv @@
// ----------------------------------------------------------------------------
// bba_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule : bba_ram

`default_nettype wire

@@ rtl/bitmap_block_allocator.sv @@
// ----------------------------------------------------------------------------
// bitmap_block_allocator: first-fit bitmap block allocator
// Keeps one used bit per block in a word RAM plus a used-block count, and
// serves allocate, free, release-region and reserve-region requests.
// ----------------------------------------------------------------------------
// After reset the block sweeps the bitmap RAM, writing one word per cycle to
// mark every block used; no request is taken meanwhile. One request is
// worked at a time. An allocate scans the bitmap one word per cycle with a
// pipelined read; a request that cannot succeed by count fails without a
// scan. A run is then marked by walking the map from word 0: each word
// wholly below the run is stepped over, and each word the run touches takes
// a read-modify-write; a release then re-reserves block 0. The result waits
// in an output register, and the next request is accepted while it does.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_block_allocator #(
  parameter int unsigned NUM_BLOCKS = 1024,
  parameter int unsigned WORD_BITS  = 32
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // configuration write channel
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [bba_pkg::CNT_W-1:0]   cfg_data_i,
  // request channel
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [bba_pkg::CMD_W-1:0]   cmd_i,
  input  wire logic [bba_pkg::START_W-1:0] start_block_i,
  input  wire logic [bba_pkg::CNT_W-1:0]   block_count_i,
  // result channel
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic                             ok_o,
  output logic [bba_pkg::START_W-1:0]      alloc_start_o,
  output logic [bba_pkg::CNT_W-1:0]        used_count_o,
  output logic [bba_pkg::CNT_W-1:0]        free_count_o
);

  localparam int unsigned CNT_W     = bba_pkg::CNT_W;
  localparam int unsigned START_W   = bba_pkg::START_W;
  localparam int unsigned MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned LAST_WORD = MAP_WORDS - 1;
  localparam int unsigned POS_W     = $clog2(NUM_BLOCKS + 4096);
  localparam int unsigned UC_W      = ($clog2(NUM_BLOCKS + 1) > CNT_W) ?
                                      $clog2(NUM_BLOCKS + 1) : CNT_W;
  localparam int unsigned LU_W      = $clog2(WORD_BITS + 1);
  localparam int unsigned LVL       = $clog2(WORD_BITS);

  // Sequencer states
  localparam logic [2:0] ST_INIT = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_MRD  = 3'd4;
  localparam logic [2:0] ST_MWR  = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  // Control registers
  logic [2:0]       state_q, state_d;
  logic [POS_W-1:0] w_q, w_d;
  logic [UC_W-1:0]  used_q, used_d;
  logic [CNT_W-1:0] total_q;
  logic             out_valid_q, out_valid_d;
  logic             rv_q, rv_d;

  // Payload registers
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               alloc_q, alloc_d;
  logic               sub_q, sub_d;
  logic               ok_q, ok_d;
  logic               val_q, val_d;
  logic               rel_q, rel_d;
  logic [POS_W-1:0]   start_q, start_d;
  logic [POS_W-1:0]   end_q, end_d;
  logic [POS_W-1:0]   base_q, base_d;
  logic [POS_W-1:0]   cbase_q, cbase_d;
  logic [POS_W-1:0]   carry_q, carry_d;
  logic               res_ok_q, res_ok_d;
  logic [START_W-1:0] res_start_q, res_start_d;
  logic [CNT_W-1:0]   res_used_q, res_used_d;
  logic [CNT_W-1:0]   res_free_q, res_free_d;

  // RAM port
  logic                 ram_we;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;

  // Effective total and free count
  logic [UC_W-1:0] eff_total;
  logic [UC_W-1:0] free_now;

  // Scan datapath
  logic [WORD_BITS-1:0] scan_used;
  logic [LU_W-1:0]      lu [LVL+1][WORD_BITS];
  logic [POS_W-1:0]     run_len [WORD_BITS];
  logic [WORD_BITS-1:0] hit;
  logic                 hit_any;
  logic [POS_W-1:0]     hit_idx;
  logic [POS_W-1:0]     where;

  // Marking mask
  logic [WORD_BITS-1:0] mark_mask;
  logic                 mark_more;
  logic                 mark_skip;

  // Count update
  logic [UC_W:0]   add_sum;
  logic [UC_W-1:0] add_res;
  logic [UC_W-1:0] sub_res;
  logic [UC_W-1:0] used_new;
  logic [UC_W-1:0] free_new;
  logic            in_accept;
  logic            out_free;

  assign cfg_ready_o   = 1'b1;
  assign in_stall_o    = (state_q != ST_IDLE);
  assign in_accept     = in_valid_i && !in_stall_o;
  assign out_valid_o   = out_valid_q;
  assign out_free      = !out_valid_q || !out_stall_i;
  assign ok_o          = res_ok_q;
  assign alloc_start_o = res_start_q;
  assign used_count_o  = res_used_q;
  assign free_count_o  = res_free_q;

  // Clamp the total to the map size
  assign eff_total = (UC_W'(total_q) > UC_W'(NUM_BLOCKS)) ? UC_W'(NUM_BLOCKS)
                                                          : UC_W'(total_q);
  assign free_now  = (used_q >= eff_total) ? '0 : eff_total - used_q;

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS),
    .AW    (AW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (w_q[AW-1:0]),
    .wdata_i (ram_wdata),
    .raddr_i (w_q[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // Find the lowest free run in the word under check
  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      scan_used[j] = ram_rdata[j] ||
                     ((cbase_q + POS_W'(j)) >= POS_W'(eff_total));
      lu[0][j] = scan_used[j] ? LU_W'(j + 1) : '0;
    end
    // prefix of the last used position, one doubling per level
    for (int s = 0; s < LVL; s++) begin
      for (int j = 0; j < WORD_BITS; j++) begin
        if (j >= (1 << s) && lu[s][j] == '0) begin
          lu[s+1][j] = lu[s][j - (1 << s)];
        end else begin
          lu[s+1][j] = lu[s][j];
        end
      end
    end
    for (int j = 0; j < WORD_BITS; j++) begin
      if (lu[LVL][j] != '0) begin
        run_len[j] = POS_W'(j + 1) - POS_W'(lu[LVL][j]);
      end else begin
        run_len[j] = carry_q + POS_W'(j + 1);
      end
      hit[j] = run_len[j] >= POS_W'(cnt_q);
    end
    hit_any = |hit;
    hit_idx = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (hit[j]) begin
        hit_idx = POS_W'(j);
      end
    end
    where = cbase_q + hit_idx + POS_W'(1) - POS_W'(cnt_q);
  end

  // Mask of run bits inside the current word
  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      mark_mask[j] = ((base_q + POS_W'(j)) >= start_q) &&
                     ((base_q + POS_W'(j)) < end_q) &&
                     ((base_q + POS_W'(j)) < POS_W'(NUM_BLOCKS));
    end
    mark_more = (w_q <= POS_W'(LAST_WORD)) && (base_q < end_q);
    mark_skip = (w_q <= POS_W'(LAST_WORD)) &&
                ((base_q + POS_W'(WORD_BITS)) <= start_q);
  end

  // Saturating count update
  always_comb begin
    add_sum = (UC_W+1)'(used_q) + (UC_W+1)'(cnt_q);
    add_res = (add_sum > (UC_W+1)'(eff_total)) ? eff_total : add_sum[UC_W-1:0];
    if (add_res < used_q) begin
      add_res = used_q;
    end
    sub_res = (UC_W'(cnt_q) >= used_q) ? '0 : used_q - UC_W'(cnt_q);
    if (sub_q) begin
      used_new = sub_res;
    end else if (!alloc_q || ok_q) begin
      used_new = add_res;
    end else begin
      used_new = used_q;
    end
    free_new = (used_new >= eff_total) ? '0 : eff_total - used_new;
  end

  // RAM write data
  always_comb begin
    ram_we    = (state_q == ST_INIT) || (state_q == ST_MWR);
    ram_wdata = '1;
    if (state_q == ST_MWR) begin
      ram_wdata = val_q ? (ram_rdata | mark_mask) : (ram_rdata & ~mark_mask);
    end
  end

  // Sequencer
  always_comb begin
    state_d     = state_q;
    w_d         = w_q;
    used_d      = used_q;
    out_valid_d = out_valid_q;
    rv_d        = rv_q;
    cnt_d       = cnt_q;
    alloc_d     = alloc_q;
    sub_d       = sub_q;
    ok_d        = ok_q;
    val_d       = val_q;
    rel_d       = rel_q;
    start_d     = start_q;
    end_d       = end_q;
    base_d      = base_q;
    cbase_d     = cbase_q;
    carry_d     = carry_q;
    res_ok_d    = res_ok_q;
    res_start_d = res_start_q;
    res_used_d  = res_used_q;
    res_free_d  = res_free_q;

    // drop the result once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_INIT: begin
        w_d = w_q + POS_W'(1);
        if (w_q == POS_W'(LAST_WORD)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_accept) begin
          cnt_d   = block_count_i;
          alloc_d = (cmd_i == bba_pkg::CMD_ALLOC);
          sub_d   = (cmd_i == bba_pkg::CMD_FREE) || (cmd_i == bba_pkg::CMD_RELEASE);
          rel_d   = (cmd_i == bba_pkg::CMD_RELEASE);
          val_d   = (cmd_i == bba_pkg::CMD_RESERVE);
          if (cmd_i == bba_pkg::CMD_ALLOC) begin
            ok_d    = 1'b0;
            w_d     = '0;
            base_d  = '0;
            rv_d    = 1'b0;
            carry_d = '0;
            if (block_count_i != '0 && free_now >= UC_W'(block_count_i)) begin
              state_d = ST_SCAN;
            end else begin
              state_d = ST_FIN;
            end
          end else begin
            ok_d    = 1'b1;
            start_d = POS_W'(start_block_i);
            end_d   = POS_W'(start_block_i) + POS_W'(block_count_i);
            w_d     = '0;
            base_d  = '0;
            state_d = ST_MRD;
          end
        end
      end

      ST_SCAN: begin
        // issue the next word read while checking the previous one
        rv_d = base_q < POS_W'(eff_total);
        if (rv_d) begin
          cbase_d = base_q;
          w_d     = w_q + POS_W'(1);
          base_d  = base_q + POS_W'(WORD_BITS);
        end
        if (rv_q) begin
          carry_d = run_len[WORD_BITS-1];
        end
        if (rv_q && hit_any) begin
          ok_d    = 1'b1;
          val_d   = 1'b1;
          start_d = where;
          end_d   = where + POS_W'(cnt_q);
          w_d     = '0;
          base_d  = '0;
          state_d = ST_MRD;
        end else if (!rv_q && !rv_d) begin
          state_d = ST_FIN;
        end
      end

      ST_MRD: begin
        if (mark_skip) begin
          // step over a word wholly below the run
          w_d    = w_q + POS_W'(1);
          base_d = base_q + POS_W'(WORD_BITS);
        end else if (mark_more) begin
          state_d = ST_MWR;
        end else if (rel_q) begin
          // re-reserve block 0 after a release
          rel_d   = 1'b0;
          val_d   = 1'b1;
          start_d = '0;
          end_d   = POS_W'(1);
          w_d     = '0;
          base_d  = '0;
        end else begin
          state_d = ST_FIN;
        end
      end

      ST_MWR: begin
        w_d     = w_q + POS_W'(1);
        base_d  = base_q + POS_W'(WORD_BITS);
        state_d = ST_MRD;
      end

      ST_FIN: begin
        if (out_free) begin
          used_d      = used_new;
          res_ok_d    = ok_q;
          res_start_d = (alloc_q && ok_q) ? start_q[START_W-1:0] : '0;
          res_used_d  = used_new[CNT_W-1:0];
          res_free_d  = free_new[CNT_W-1:0];
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      w_q         <= '0;
      used_q      <= UC_W'(NUM_BLOCKS);
      total_q     <= CNT_W'(1024);
      out_valid_q <= 1'b0;
      rv_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      w_q         <= w_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
      rv_q        <= rv_d;
      if (cfg_valid_i && cfg_ready_o) begin
        total_q <= cfg_data_i;
      end
    end
  end

  // Payload state
  always_ff @(posedge clk_i) begin
    cnt_q       <= cnt_d;
    alloc_q     <= alloc_d;
    sub_q       <= sub_d;
    ok_q        <= ok_d;
    val_q       <= val_d;
    rel_q       <= rel_d;
    start_q     <= start_d;
    end_q       <= end_d;
    base_q      <= base_d;
    cbase_q     <= cbase_d;
    carry_q     <= carry_d;
    res_ok_q    <= res_ok_d;
    res_start_q <= res_start_d;
    res_used_q  <= res_used_d;
    res_free_q  <= res_free_d;
  end

endmodule : bitmap_block_allocator

`default_nettype wire
